FILE: src/icmpr_pkg.sv
// Package for the ICMP echo reply rewriter: header geometry, verdict codes,
// the RAM request and result-load structs, and the reply byte-map functions.
// No dependencies.
`timescale 1ns / 1ps

package icmpr_pkg;

   localparam int HDR_LEN  = 42;
   localparam int ADDR_W   = $clog2(HDR_LEN);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(HDR_LEN - 1);

   localparam logic [ADDR_W-1:0] POS_ETYPE_HI = ADDR_W'(12);
   localparam logic [ADDR_W-1:0] POS_ETYPE_LO = ADDR_W'(13);
   localparam logic [ADDR_W-1:0] POS_IP_PROTO = ADDR_W'(23);

   localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
   localparam logic [7:0] PROTO_ICMP    = 8'h01;

   localparam logic [1:0] V_DROP = 2'd0;
   localparam logic [1:0] V_PASS = 2'd1;
   localparam logic [1:0] V_TX   = 2'd2;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } hdr_ram_req_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] verdict;
   } rsp_load_type;

   // Store address that feeds reply byte idx: MACs swap, IP addresses swap.
   function automatic logic [ADDR_W-1:0] hdr_src_addr(input logic [ADDR_W-1:0] idx,
                                                      input logic tx);
      logic [ADDR_W-1:0] a;
      a = idx;
      if (tx) begin
         if (idx inside {[0:5]}) begin
            a = idx + ADDR_W'(6);
         end else if (idx inside {[6:11]}) begin
            a = idx - ADDR_W'(6);
         end else if (idx inside {[26:29]}) begin
            a = idx + ADDR_W'(4);
         end else if (idx inside {[30:33]}) begin
            a = idx - ADDR_W'(4);
         end
      end
      return a;
   endfunction

   // Checksum, ICMP type and code bytes go out as zero in a reply.
   function automatic logic hdr_zeroed(input logic [ADDR_W-1:0] idx, input logic tx);
      return tx && (idx inside {24, 25, [34:37]});
   endfunction

endpackage

FILE: src/icmpr_req_if.sv
// Input channel: one frame byte per transaction with end-of-frame flag.
// No dependencies.
`timescale 1ns / 1ps

interface icmpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: src/icmpr_rsp_if.sv
// Result channel: one output byte per transaction with last flag and verdict.
// No dependencies.
`timescale 1ns / 1ps

interface icmpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] verdict;

   modport source (output valid, output out_byte, output out_last, output verdict,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input verdict,
                   output ready);
endinterface

FILE: src/icmpr_hdr_ram.sv
// Header store: 42 x 8 synchronous RAM, one write and one registered read port.
// Depends on icmpr_pkg.
`timescale 1ns / 1ps

module icmpr_hdr_ram (
   input  logic                     clock,
   input  icmpr_pkg::hdr_ram_req_type req,
   output logic [7:0]               rdata
);
   import icmpr_pkg::*;

   logic [7:0] mem_ff [HDR_LEN];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem_ff[req.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/icmpr_seq.sv
// Frame sequencer: writes the header into the store, picks the verdict,
// reads the reply burst back out through the byte map, streams the payload.
// Depends on icmpr_pkg.
`timescale 1ns / 1ps

module icmpr_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [7:0]                req_in_byte,
   input  logic                      req_in_last,
   output logic                      req_ready,
   input  logic                      slot_free,
   output icmpr_pkg::hdr_ram_req_type ram_req,
   input  logic [7:0]                ram_rdata,
   output icmpr_pkg::rsp_load_type   rsp_load
);
   import icmpr_pkg::*;

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_BURST   = 2'd1;
   localparam logic [1:0] ST_STREAM  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [1:0]        verdict_ff, verdict_in;
   logic              last41_ff, last41_in;
   logic [2:0]        match_ff, match_in;

   logic              acc;
   logic              tx;
   logic              advance;
   logic [ADDR_W-1:0] ridx;

   assign tx        = (verdict_ff == V_TX);
   assign req_ready = ((state_ff == ST_COLLECT) || (state_ff == ST_STREAM)) && slot_free;
   assign acc       = req_valid && req_ready;
   assign advance   = (state_ff == ST_BURST) && pend_ff && slot_free;
   // the read issued alongside a load fetches the following byte
   assign ridx      = pend_ff ? idx_ff + ADDR_W'(1) : idx_ff;

   always_comb begin
      ram_req.we    = acc && (state_ff == ST_COLLECT);
      ram_req.waddr = pos_ff;
      ram_req.wdata = req_in_byte;
      ram_req.re    = (state_ff == ST_BURST) && (!pend_ff || (slot_free && idx_ff != LAST_IDX));
      ram_req.raddr = hdr_src_addr(ridx, tx);
   end

   always_comb begin
      rsp_load = '{valid: 1'b0, out_byte: 8'h00, out_last: 1'b0, verdict: V_DROP};
      state_in   = state_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      verdict_in = verdict_ff;
      last41_in  = last41_ff;
      match_in   = match_ff;
      pend_in    = ram_req.re ? 1'b1 : (advance ? 1'b0 : pend_ff);

      case (state_ff)
         ST_COLLECT: begin
            if (acc) begin
               if (pos_ff == POS_ETYPE_HI) match_in[0] = (req_in_byte == ETYPE_IPV4_HI);
               if (pos_ff == POS_ETYPE_LO) match_in[1] = (req_in_byte == ETYPE_IPV4_LO);
               if (pos_ff == POS_IP_PROTO) match_in[2] = (req_in_byte == PROTO_ICMP);
               if (pos_ff == LAST_IDX) begin
                  verdict_in = (&match_ff) ? V_TX : V_PASS;
                  last41_in  = req_in_last;
                  state_in   = ST_BURST;
                  idx_in     = '0;
                  pos_in     = '0;
               end else if (req_in_last) begin
                  // short frame: single drop marker
                  rsp_load = '{valid: 1'b1, out_byte: 8'h00, out_last: 1'b1,
                               verdict: V_DROP};
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + ADDR_W'(1);
               end
            end
         end
         ST_BURST: begin
            if (advance) begin
               rsp_load.valid    = 1'b1;
               rsp_load.out_byte = hdr_zeroed(idx_ff, tx) ? 8'h00 : ram_rdata;
               rsp_load.out_last = (idx_ff == LAST_IDX) && last41_ff;
               rsp_load.verdict  = verdict_ff;
               if (idx_ff == LAST_IDX) begin
                  state_in = last41_ff ? ST_COLLECT : ST_STREAM;
                  if (last41_ff) verdict_in = V_DROP;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end
         end
         ST_STREAM: begin
            if (acc) begin
               rsp_load = '{valid: 1'b1, out_byte: req_in_byte, out_last: req_in_last,
                            verdict: verdict_ff};
               if (req_in_last) begin
                  state_in   = ST_COLLECT;
                  verdict_in = V_DROP;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_COLLECT;
         pos_ff     <= '0;
         idx_ff     <= '0;
         pend_ff    <= 1'b0;
         verdict_ff <= V_DROP;
         last41_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         idx_ff     <= idx_in;
         pend_ff    <= pend_in;
         verdict_ff <= verdict_in;
         last41_ff  <= last41_in;
      end
      match_ff <= match_in;
   end
endmodule

FILE: src/icmpr_hdr_ram_wrap_unused.sv
// Intentionally minimal: not instantiated elsewhere.
`timescale 1ns / 1ps

FILE: src/icmp_echo_reply_rewriter_core.sv
// ICMP echo reply rewriter: takes an Ethernet frame one byte per transaction,
// holds the first 42 bytes in a header RAM and answers IPv4/ICMP frames with
// a rewritten reply header (MACs and IP addresses swapped, checksums, ICMP
// type and code zeroed), other frames pass unchanged and frames shorter than
// 42 bytes give a single drop marker. Header bytes and payload bytes are
// taken at one per cycle while the output register is free. After byte 41
// the input stalls while the 42-byte header burst is read back from the
// RAM, one byte per cycle without output back-pressure. Results go through
// a one-entry output register; input is held off while a result waits to
// be taken.
// Depends on icmpr_pkg, icmpr_req_if, icmpr_rsp_if, icmpr_hdr_ram, icmpr_seq.
`timescale 1ns / 1ps

module icmp_echo_reply_rewriter_core (
   input logic          clock,
   input logic          reset,
   icmpr_req_if.sink    req,
   icmpr_rsp_if.source  rsp
);
   import icmpr_pkg::*;

   hdr_ram_req_type ram_req;
   rsp_load_type    rsp_load;
   logic [7:0]      ram_rdata;
   logic            slot_free;

   logic            out_v_ff, out_v_in;
   logic [7:0]      out_byte_ff;
   logic            out_last_ff;
   logic [1:0]      out_verdict_ff;

   assign slot_free = !out_v_ff || rsp.ready;

   icmpr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_in_byte (req.in_byte),
      .req_in_last (req.in_last),
      .req_ready   (req.ready),
      .slot_free   (slot_free),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata),
      .rsp_load    (rsp_load)
   );

   icmpr_hdr_ram u_hdr_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   assign out_v_in = rsp_load.valid ? 1'b1 : (rsp.ready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (rsp_load.valid) begin
         out_byte_ff    <= rsp_load.out_byte;
         out_last_ff    <= rsp_load.out_last;
         out_verdict_ff <= rsp_load.verdict;
      end
   end

   assign rsp.valid    = out_v_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.out_last = out_last_ff;
   assign rsp.verdict  = out_verdict_ff;

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp.ready) |-> !rsp_load.valid)
      else $error("result load while output register is stalled");

   // drop marker is always a lone zero byte that ends the frame
   a_drop_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.verdict == V_DROP) |-> (rsp.out_last && rsp.out_byte == 8'h00))
      else $error("malformed drop marker");

   // header capture and burst readout never overlap
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> !ram_req.re)
      else $error("header RAM written during burst readout");

   // input is held off until the burst read pipeline is idle
   a_no_accept_in_burst: assert property (@(posedge clock) disable iff (reset)
      ram_req.re |-> !req.ready)
      else $error("input accepted during header burst");
endmodule

FILE: verif/icmp_echo_reply_rewriter_core_test.sv
// Testbench for icmp_echo_reply_rewriter_core: sends Ethernet frames byte by byte
// with random gaps and output stalls, predicts or types in every reply byte and compares it.
// Depends on icmpr_pkg, icmpr_req_if, icmpr_rsp_if and the core RTL.
`timescale 1ns / 1ps

module icmp_echo_reply_rewriter_core_test;
   import icmpr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 50;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] verdict;
   } reply_type;

   typedef struct {
      int unsigned len;
      logic [15:0] etype;
      logic [7:0]  proto;
      logic [7:0]  fill;
      bit          rnd;
      logic [1:0]  verdict;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset;

   icmpr_req_if req_ch ();
   icmpr_rsp_if rsp_ch ();

   icmp_echo_reply_rewriter_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the block state
   logic [7:0] shadow_hdr [HDR_LEN];
   logic [5:0] shadow_pos;
   logic [1:0] shadow_verdict;

   reply_type reply_due [$];
   reply_type predicted [$];

   int        mismatch_count = 0;
   int        bytes_sent     = 0;
   int        cycle_count    = 0;
   int        rsp_taken      = 0;
   int        idle_mode      = 0;
   bit        typed_now      = 1'b0;
   reply_type typed_reply    = '0;

   // directed frames; short frames and trailing bytes of pass and reply frames
   // have their results typed in, header bursts go through the predictor
   frame_row_type plan [8] = '{
      '{1,  16'h0800, 8'h01, 8'h00, 1'b0, V_DROP},
      '{1,  16'h0800, 8'h01, 8'hFF, 1'b0, V_DROP},
      '{2,  16'h0800, 8'h01, 8'hA5, 1'b0, V_DROP},
      '{41, 16'h0800, 8'h01, 8'h5A, 1'b0, V_DROP},
      '{42, 16'h0800, 8'h01, 8'hFF, 1'b0, V_TX},
      '{43, 16'h0801, 8'h01, 8'h00, 1'b1, V_PASS},
      '{43, 16'h0800, 8'h06, 8'h00, 1'b1, V_PASS},
      '{43, 16'h0800, 8'h01, 8'h00, 1'b1, V_TX}
   };

   function automatic int unsigned draw_gap();
      int unsigned g;
      g = 0;
      case (idle_mode)
         1: if ($urandom_range(0, 3) == 0) g = $urandom_range(1, 16);
         2: g = $urandom_range(0, 16);
         default: g = 0;
      endcase
      return g;
   endfunction

   // one input byte through the rewriter; results land in predicted
   function automatic void predict_reply(input logic [7:0] b, input logic l);
      logic [7:0] t;
      predicted.delete();
      if (shadow_pos >= 6'(HDR_LEN)) begin
         predicted.push_back('{b, l, shadow_verdict});
         if (l) begin
            shadow_pos     = '0;
            shadow_verdict = V_DROP;
         end
         return;
      end
      shadow_hdr[shadow_pos] = b;
      if (shadow_pos < 6'(HDR_LEN - 1)) begin
         if (l) begin
            predicted.push_back('{8'h00, 1'b1, V_DROP});
            shadow_pos     = '0;
            shadow_verdict = V_DROP;
         end else begin
            shadow_pos = shadow_pos + 6'd1;
         end
         return;
      end
      if (shadow_hdr[12] != ETYPE_IPV4_HI || shadow_hdr[13] != ETYPE_IPV4_LO ||
          shadow_hdr[23] != PROTO_ICMP) begin
         shadow_verdict = V_PASS;
      end else begin
         shadow_verdict = V_TX;
         for (int i = 0; i < 6; i++) begin
            t                 = shadow_hdr[i];
            shadow_hdr[i]     = shadow_hdr[i + 6];
            shadow_hdr[i + 6] = t;
         end
         for (int i = 26; i < 30; i++) begin
            t                 = shadow_hdr[i];
            shadow_hdr[i]     = shadow_hdr[i + 4];
            shadow_hdr[i + 4] = t;
         end
         shadow_hdr[24] = 8'h00;
         shadow_hdr[25] = 8'h00;
         for (int i = 34; i < 38; i++) shadow_hdr[i] = 8'h00;
      end
      for (int i = 0; i < HDR_LEN; i++) begin
         predicted.push_back('{shadow_hdr[i], (i == HDR_LEN - 1) ? l : 1'b0, shadow_verdict});
      end
      if (l) begin
         shadow_pos     = '0;
         shadow_verdict = V_DROP;
      end else begin
         shadow_pos = 6'(HDR_LEN);
      end
   endfunction

   // input acceptance feeds the predictor, result acceptance is checked
   always @(posedge clock) begin : watch_channels
      reply_type got;
      reply_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predict_reply(req_ch.in_byte, req_ch.in_last);
            if (typed_now) begin
               reply_due.push_back(typed_reply);
            end else begin
               foreach (predicted[i]) reply_due.push_back(predicted[i]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.verdict};
            rsp_taken <= rsp_taken + 1;
            if (reply_due.size() == 0) begin
               $display("%0t: unexpected transaction byte %h last %b verdict %0d",
                        $time, got.data, got.last, got.verdict);
               mismatch_count++;
            end else begin
               want = reply_due.pop_front();
               if (got.data !== want.data || got.last !== want.last ||
                   got.verdict !== want.verdict) begin
                  $display("%0t: mismatch expected byte %h last %b verdict %0d, actual byte %h last %b verdict %0d",
                           $time, want.data, want.last, want.verdict,
                           got.data, got.last, got.verdict);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d transactions still expected", $time, reply_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: stall after each taken transaction for a drawn count
   always @(negedge clock) begin : drive_ready
      int          taken_seen;
      int unsigned stall_left;
      if (rsp_taken != taken_seen) begin
         taken_seen = rsp_taken;
         stall_left = draw_gap();
      end
      if (reset || stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         if (stall_left != 0) stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // called and returns at a falling edge
   task automatic push_byte(input logic [7:0] b, input logic l, input bit t,
                            input reply_type tr);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= l;
      typed_now   = t;
      typed_reply = tr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input int unsigned len, input logic [15:0] etype,
                             input logic [7:0] proto, input logic [7:0] fill,
                             input bit rnd, input bit typed, input logic [1:0] v);
      logic [7:0] b;
      logic       l;
      bit         t;
      reply_type  tr;
      for (int unsigned i = 0; i < len; i++) begin
         b = rnd ? 8'($urandom) : fill;
         if (i == 12) b = etype[15:8];
         else if (i == 13) b = etype[7:0];
         else if (i == 23) b = proto;
         l  = (i == len - 1);
         t  = 1'b0;
         tr = '0;
         if (typed && len < HDR_LEN && l) begin
            t  = 1'b1;
            tr = '{8'h00, 1'b1, V_DROP};
         end else if (typed && i >= HDR_LEN) begin
            t  = 1'b1;
            tr = '{b, l, v};
         end
         push_byte(b, l, t, tr);
      end
   endtask

   initial begin
      int unsigned kind;
      int unsigned len;
      logic [15:0] etype;
      logic [7:0]  proto;
      int          random_start;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      shadow_pos     = '0;
      shadow_verdict = V_DROP;
      foreach (shadow_hdr[i]) shadow_hdr[i] = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         idle_mode = $urandom_range(0, 2);
         send_frame(plan[r].len, plan[r].etype, plan[r].proto, plan[r].fill,
                    plan[r].rnd, 1'b1, plan[r].verdict);
      end

      // mostly echo requests with random content, some other traffic, some runts
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         idle_mode = $urandom_range(0, 2);
         kind      = $urandom_range(0, 19);
         etype     = 16'h0800;
         proto     = PROTO_ICMP;
         len       = HDR_LEN + $urandom_range(0, 10);
         if (kind < 3) begin
            len = $urandom_range(1, HDR_LEN - 1);
         end else if (kind < 6) begin
            if ($urandom_range(0, 1) == 0) etype = 16'h0800 ^ (16'd1 << $urandom_range(0, 15));
            else etype = 16'($urandom);
            if ($urandom_range(0, 1) == 0) proto = 8'($urandom);
         end
         send_frame(len, etype, proto, 8'h00, 1'b1, 1'b0, V_DROP);
      end
      req_ch.valid <= 1'b0;
      typed_now = 1'b0;

      while (reply_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && reply_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
